/* hdl/euler_angles_to_basis_vectors_unit_assert.svh */
// Assertion macros for the Euler angles to basis vectors unit.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef EULER_ANGLES_TO_BASIS_VECTORS_UNIT_ASSERT_SVH
`define EULER_ANGLES_TO_BASIS_VECTORS_UNIT_ASSERT_SVH

// same-cycle implication
`define EAB_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define EAB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/eab_pkg.sv */
// Shared types, constants and the rounding product for the basis vector unit.
// No dependencies.
package eab_pkg;

   localparam int ANGLE_WIDTH = 18;
   localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961321;
   localparam logic [31:0] Q31_ONE = 32'h8000_0000;

   // floor(n/d) = (n*m) >> s for n < 2^31, m = ceil(2^s/d), s = 31 + ceil(log2 d)
   localparam logic [31:0] SIN_RCP [7] = '{
      32'(((64'd1 << 39) + 64'd209) / 64'd210),
      32'(((64'd1 << 39) + 64'd155) / 64'd156),
      32'(((64'd1 << 38) + 64'd109) / 64'd110),
      32'(((64'd1 << 38) + 64'd71) / 64'd72),
      32'(((64'd1 << 37) + 64'd41) / 64'd42),
      32'(((64'd1 << 36) + 64'd19) / 64'd20),
      32'(((64'd1 << 34) + 64'd5) / 64'd6)};
   localparam int SIN_SHF [7] = '{39, 39, 38, 38, 37, 36, 34};
   localparam logic [31:0] COS_RCP [7] = '{
      32'(((64'd1 << 39) + 64'd181) / 64'd182),
      32'(((64'd1 << 39) + 64'd131) / 64'd132),
      32'(((64'd1 << 38) + 64'd89) / 64'd90),
      32'(((64'd1 << 37) + 64'd55) / 64'd56),
      32'(((64'd1 << 36) + 64'd29) / 64'd30),
      32'(((64'd1 << 35) + 64'd11) / 64'd12),
      32'(((64'd1 << 32) + 64'd1) / 64'd2)};
   localparam int COS_SHF [7] = '{39, 39, 38, 37, 36, 35, 32};

   // quadrant codes
   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   // side data that rides along the series pipeline
   typedef struct packed {
      logic [30:0] x;
      logic [30:0] x2;
      quad_type    quad;
      logic        swap;
   } sc_carry_type;

   // one less than the number of compare-subtract steps to reduce a signed angle modulo 360 degrees
   function automatic int red_steps(input int f);
      int k;
      k = 0;
      for (int i = 0; i < 8; i++) begin
         if (((64'd360 << f) << i) < (64'd1 << (ANGLE_WIDTH - 1))) k = i + 1;
      end
      return k;
   endfunction

   // Q1.31 sign-magnitude product, rounded half away from zero
   function automatic logic signed [32:0] qmul(input logic signed [32:0] a,
                                               input logic signed [32:0] b);
      logic [31:0] ma;
      logic [31:0] mb;
      logic [63:0] p;
      logic [32:0] m;
      ma = a[32] ? 32'(-a) : 32'(a);
      mb = b[32] ? 32'(-b) : 32'(b);
      p = ma * mb;
      m = 33'((p + (64'd1 << 30)) >> 31);
      return (a[32] ^ b[32]) ? -signed'(m) : signed'(m);
   endfunction

endpackage

/* hdl/eab_step.sv */
// One Taylor series step for sine and cosine: two register stages.
// Depends on eab_pkg.
module eab_step import eab_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic         clock,
   input  logic         adv,
   input  sc_carry_type carry_i,
   input  logic [31:0]  ts_i,
   input  logic [31:0]  tc_i,
   output sc_carry_type carry_o,
   output logic [31:0]  ts_o,
   output logic [31:0]  tc_o
);

   sc_carry_type carry_a_ff, carry_a_in, carry_b_ff;
   logic [30:0]  ns_ff, ns_in, nc_ff, nc_in;
   logic [31:0]  ts_ff, ts_in, tc_ff, tc_in;
   logic [62:0]  ps, pc, qs, qc;

   // stage A: x2*t >> 31
   always_comb begin
      carry_a_in = carry_i;
      ps = carry_i.x2 * ts_i;
      pc = carry_i.x2 * tc_i;
      ns_in = ps[61:31];
      nc_in = pc[61:31];
   end

   // stage B: divide by constant through reciprocal, subtract from one
   always_comb begin
      qs = ns_ff * SIN_RCP[IDX];
      qc = nc_ff * COS_RCP[IDX];
      ts_in = Q31_ONE - 32'(qs >> SIN_SHF[IDX]);
      tc_in = Q31_ONE - 32'(qc >> COS_SHF[IDX]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         carry_a_ff <= carry_a_in;
         ns_ff      <= ns_in;
         nc_ff      <= nc_in;
         carry_b_ff <= carry_a_ff;
         ts_ff      <= ts_in;
         tc_ff      <= tc_in;
      end
   end

   assign carry_o = carry_b_ff;
   assign ts_o    = ts_ff;
   assign tc_o    = tc_ff;

endmodule

/* hdl/eab_sincos.sv */
// Sine and cosine of one angle in degrees: reduce, fold, scale, series, unfold.
// Depends on eab_pkg and eab_step.
module eab_sincos import eab_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 8
) (
   input  logic                          clock,
   input  logic                          adv,
   input  logic signed [ANGLE_WIDTH-1:0] angle_i,
   output logic signed [32:0]            sin_o,
   output logic signed [32:0]            cos_o
);

   localparam int F  = ANGLE_FRAC_BITS;
   localparam int K  = red_steps(F);
   localparam int RW = (F + 10 > 19) ? F + 11 : 20;
   localparam int AW = F + 9;
   localparam int WW = F + 7;
   localparam logic [RW-1:0] FULL  = RW'(360) << F;
   localparam logic [RW-1:0] FULLK = FULL << K;
   localparam logic [AW-1:0] QTR   = AW'(90) << F;
   localparam logic [AW-1:0] QTR2  = AW'(180) << F;
   localparam logic [AW-1:0] QTR3  = AW'(270) << F;
   localparam logic [WW-1:0] OCT   = WW'(45) << F;

   logic [RW-1:0] u;
   logic [AW-1:0] a_ff, a_in;
   logic [AW-1:0] w_full;
   logic [WW-1:0] w_ff, w_in;
   quad_type      quad1_ff, quad1_in, quad2_ff;
   logic          swap1_ff, swap1_in, swap2_ff;
   logic [F+33:0] xprod;
   logic [30:0]   x_ff;
   logic [61:0]   sq;
   sc_carry_type  head_ff, head_in;
   sc_carry_type  carry [8];
   logic [31:0]   ts [8];
   logic [31:0]   tc [8];
   logic [62:0]   sprod;
   logic signed [32:0] ser_s, ser_c, ps, pc;
   logic signed [32:0] sin_ff, sin_in, cos_ff, cos_in;

   // stage 1: modulo 360 by offset and compare-subtract
   always_comb begin
      u = RW'(angle_i) + FULLK;
      for (int k = K; k >= 0; k--) begin
         if (u >= (FULL << k)) u = u - (FULL << k);
      end
      a_in = AW'(u);
   end

   // stage 2: quadrant and octant fold
   always_comb begin
      if (a_ff >= QTR3) begin
         quad1_in = QUAD_3;
         w_full   = a_ff - QTR3;
      end else if (a_ff >= QTR2) begin
         quad1_in = QUAD_2;
         w_full   = a_ff - QTR2;
      end else if (a_ff >= QTR) begin
         quad1_in = QUAD_1;
         w_full   = a_ff - QTR;
      end else begin
         quad1_in = QUAD_0;
         w_full   = a_ff;
      end
      swap1_in = WW'(w_full) > OCT;
      w_in     = swap1_in ? WW'(QTR - w_full) : WW'(w_full);
   end

   // stage 3: degrees to radians, Q1.31
   assign xprod = w_ff * DEG_TO_RAD_Q32;

   // stage 4: square
   always_comb begin
      sq           = x_ff * x_ff;
      head_in.x    = x_ff;
      head_in.x2   = sq[61:31];
      head_in.quad = quad2_ff;
      head_in.swap = swap2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff     <= a_in;
         w_ff     <= w_in;
         quad1_ff <= quad1_in;
         swap1_ff <= swap1_in;
         x_ff     <= xprod[F+31:F+1];
         quad2_ff <= quad1_ff;
         swap2_ff <= swap1_ff;
         head_ff  <= head_in;
      end
   end

   assign carry[0] = head_ff;
   assign ts[0]    = Q31_ONE;
   assign tc[0]    = Q31_ONE;

   for (genvar i = 0; i < 7; i++) begin : g_step
      eab_step #(.IDX(i)) u_step (
         .clock   (clock),
         .adv     (adv),
         .carry_i (carry[i]),
         .ts_i    (ts[i]),
         .tc_i    (tc[i]),
         .carry_o (carry[i+1]),
         .ts_o    (ts[i+1]),
         .tc_o    (tc[i+1])
      );
   end

   // last stage: sin = x*t, undo fold and quadrant
   always_comb begin
      sprod = carry[7].x * ts[7];
      ser_s = signed'(33'(sprod[61:31]));
      ser_c = signed'(33'(tc[7]));
      ps = carry[7].swap ? ser_c : ser_s;
      pc = carry[7].swap ? ser_s : ser_c;
      case (carry[7].quad)
         QUAD_0: begin
            sin_in = ps;
            cos_in = pc;
         end
         QUAD_1: begin
            sin_in = pc;
            cos_in = -ps;
         end
         QUAD_2: begin
            sin_in = -ps;
            cos_in = -pc;
         end
         QUAD_3: begin
            sin_in = -pc;
            cos_in = ps;
         end
         default: begin
            sin_in = ps;
            cos_in = pc;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_o = sin_ff;
   assign cos_o = cos_ff;

endmodule

/* hdl/eab_basis.sv */
// Products, sums and output rounding for the three basis vectors.
// Depends on eab_pkg.
module eab_basis import eab_pkg::*; #(
   parameter int OUT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   adv,
   input  logic signed [32:0]     sp_i,
   input  logic signed [32:0]     cp_i,
   input  logic signed [32:0]     sy_i,
   input  logic signed [32:0]     cy_i,
   input  logic signed [32:0]     sr_i,
   input  logic signed [32:0]     cr_i,
   output logic [9*OUT_WIDTH-1:0] data_o
);

   localparam int OW = OUT_WIDTH;
   localparam int SH = 32 - OW;
   localparam logic [34:0] RND  = (35'd1 << SH) >> 1;
   localparam logic [34:0] MAXV = 35'((64'd1 << (OW - 1)) - 64'd1);

   logic signed [32:0] srsp_ff, crsp_ff, cpcy_ff, cpsy_ff, crsy_ff, crcy_ff;
   logic signed [32:0] srcp_ff, srsy_ff, srcy_ff, crcp_ff;
   logic signed [32:0] sp1_ff, sy1_ff, cy1_ff;
   logic signed [32:0] t1_ff, t2_ff, t3_ff, t4_ff;
   logic signed [32:0] cpcy2_ff, cpsy2_ff, crsy2_ff, crcy2_ff, srcp2_ff;
   logic signed [32:0] srsy2_ff, srcy2_ff, crcp2_ff, sp2_ff;
   logic signed [33:0] sum [9];
   logic [9*OW-1:0]    data_ff, data_in;

   function automatic logic [OW-1:0] to_out(input logic signed [33:0] v);
      logic [34:0] mag;
      logic [34:0] r;
      mag = v[33] ? (35'd0 - 35'(v)) : 35'(v);
      r = (mag + RND) >> SH;
      if (r > MAXV) r = MAXV;
      if (v[33]) r = 35'd0 - r;
      return OW'(r);
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         srsp_ff  <= qmul(sr_i, sp_i);
         crsp_ff  <= qmul(cr_i, sp_i);
         cpcy_ff  <= qmul(cp_i, cy_i);
         cpsy_ff  <= qmul(cp_i, sy_i);
         crsy_ff  <= qmul(cr_i, sy_i);
         crcy_ff  <= qmul(cr_i, cy_i);
         srcp_ff  <= qmul(sr_i, cp_i);
         srsy_ff  <= qmul(sr_i, sy_i);
         srcy_ff  <= qmul(sr_i, cy_i);
         crcp_ff  <= qmul(cr_i, cp_i);
         sp1_ff   <= sp_i;
         sy1_ff   <= sy_i;
         cy1_ff   <= cy_i;
         // triple products, left to right
         t1_ff    <= qmul(srsp_ff, cy1_ff);
         t2_ff    <= qmul(srsp_ff, sy1_ff);
         t3_ff    <= qmul(crsp_ff, cy1_ff);
         t4_ff    <= qmul(crsp_ff, sy1_ff);
         cpcy2_ff <= cpcy_ff;
         cpsy2_ff <= cpsy_ff;
         crsy2_ff <= crsy_ff;
         crcy2_ff <= crcy_ff;
         srcp2_ff <= srcp_ff;
         srsy2_ff <= srsy_ff;
         srcy2_ff <= srcy_ff;
         crcp2_ff <= crcp_ff;
         sp2_ff   <= sp1_ff;
         data_ff  <= data_in;
      end
   end

   always_comb begin
      sum[0] = 34'(cpcy2_ff);
      sum[1] = 34'(cpsy2_ff);
      sum[2] = -34'(sp2_ff);
      sum[3] = 34'(crsy2_ff) - 34'(t1_ff);
      sum[4] = -34'(t2_ff) - 34'(crcy2_ff);
      sum[5] = -34'(srcp2_ff);
      sum[6] = 34'(t3_ff) + 34'(srsy2_ff);
      sum[7] = 34'(t4_ff) - 34'(srcy2_ff);
      sum[8] = 34'(crcp2_ff);
      for (int i = 0; i < 9; i++) begin
         data_in[i*OW +: OW] = to_out(sum[i]);
      end
   end

   assign data_o = data_ff;

endmodule

/* hdl/euler_angles_to_basis_vectors_unit.sv */
// Euler angles to basis vectors: top level with handshake and valid chain.
// Depends on eab_pkg, eab_sincos, eab_basis and the assertion macro header.
//
// Usage:
//  - Input channel req_*: one transaction carries pitch, yaw and roll in
//    degrees, signed, ANGLE_FRAC_BITS fraction bits. Any 18-bit pattern is
//    reduced modulo 360 degrees.
//  - Result channel rsp_*: one transaction per input, the forward, right and
//    up vectors, nine Q1.(OUT_WIDTH-1) components; 1.0 saturates to the
//    largest code and the most negative code never appears.
//  - Throughput: one transaction per cycle while the result channel is not
//    stalled; the 19-stage sine/cosine pipe (seven two-stage series steps)
//    and the 3-stage product and rounding pipe each take a new item every
//    cycle unless the pipe is frozen.
//  - Reset clears all valid bits; data registers are not reset.
//  - When the receiver holds rsp_tready low with a result waiting, the
//    whole pipe freezes and req_tready drops; nothing is lost or repeated.
//  - The block keeps no state between transactions.
module euler_angles_to_basis_vectors_unit import eab_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 8,
   parameter int OUT_WIDTH       = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // [17:0] pitch_deg, [35:18] yaw_deg, [53:36] roll_deg, rest zero
   input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // OUT_WIDTH each from bit 0: forward_x, forward_y, forward_z, right_x,
   // right_y, right_z, up_x, up_y, up_z, rest zero
   output logic [((9*OUT_WIDTH+7)/8)*8-1:0] rsp_tdata
);

   `include "euler_angles_to_basis_vectors_unit_assert.svh"

   localparam int LAT = 22;
   localparam int ODW = ((9 * OUT_WIDTH + 7) / 8) * 8;
   localparam logic [OUT_WIDTH-1:0] MIN_CODE = {1'b1, {(OUT_WIDTH-1){1'b0}}};

   logic               adv;
   logic [LAT-1:0]     vld_ff, vld_in;
   logic signed [32:0] sp, cp, sy, cy, sr, cr;
   logic [9*OUT_WIDTH-1:0] data;

   // pipe moves whenever the output slot is empty or being drained
   assign adv        = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LAT-1];

   assign vld_in = {vld_ff[LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   eab_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
      .clock   (clock),
      .adv     (adv),
      .angle_i (signed'(req_tdata[ANGLE_WIDTH-1:0])),
      .sin_o   (sp),
      .cos_o   (cp)
   );

   eab_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_yaw (
      .clock   (clock),
      .adv     (adv),
      .angle_i (signed'(req_tdata[2*ANGLE_WIDTH-1:ANGLE_WIDTH])),
      .sin_o   (sy),
      .cos_o   (cy)
   );

   eab_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
      .clock   (clock),
      .adv     (adv),
      .angle_i (signed'(req_tdata[3*ANGLE_WIDTH-1:2*ANGLE_WIDTH])),
      .sin_o   (sr),
      .cos_o   (cr)
   );

   eab_basis #(.OUT_WIDTH(OUT_WIDTH)) u_basis (
      .clock  (clock),
      .adv    (adv),
      .sp_i   (sp),
      .cp_i   (cp),
      .sy_i   (sy),
      .cy_i   (cy),
      .sr_i   (sr),
      .cr_i   (cr),
      .data_o (data)
   );

   assign rsp_tdata = ODW'(data);

   `EAB_ASSERT_NEXT(a_accept_enters, req_tvalid && req_tready, vld_ff[0], "accepted transaction not in pipe")
   `EAB_ASSERT_NEXT(a_stall_freezes, !adv, $stable(vld_ff), "valid chain moved during stall")
   `EAB_ASSERT_NOW(a_no_min_code, rsp_tvalid, rsp_tdata[9*OUT_WIDTH-1 -: OUT_WIDTH] != MIN_CODE, "up_z hit most negative code")

endmodule
